>>> hdl/tat_pkg.sv
// tat_pkg: shared types and constants of the tree address table
// used by the channel interfaces and the top level; no dependencies
package tat_pkg;

	localparam int ADDR_W      = 8;
	localparam int KIND_W      = 2;
	localparam int FIRST_ALLOC = 2;
	localparam int WALK_LIMIT  = 256;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_ALLOC  = 2'd0;
	localparam kind_t KIND_SET    = 2'd1;
	localparam kind_t KIND_DELETE = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

endpackage

>>> hdl/tat_if.sv
// tat_if: valid/ready channel interfaces for requests, results and configuration
// depends on tat_pkg for the payload types
interface tat_req_if;
	logic           valid;
	logic           ready;
	tat_pkg::kind_t kind;
	tat_pkg::addr_t address;
	tat_pkg::addr_t parent;

	modport source (output valid, kind, address, parent, input ready);
	modport sink   (input valid, kind, address, parent, output ready);
endinterface

interface tat_rsp_if;
	logic           valid;
	logic           ready;
	tat_pkg::addr_t assigned_address;
	logic           status;

	modport source (output valid, assigned_address, status, input ready);
	modport sink   (input valid, assigned_address, status, output ready);
endinterface

interface tat_cfg_if;
	logic           valid;
	logic           ready;
	tat_pkg::addr_t data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> hdl/tat_ram.sv
// tat_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/tree_address_table_top.sv
// tree_address_table_top: parent table of a network tree with allocate, set,
// delete-subtree and clear requests; uses tat_pkg, tat_if and tat_ram
//
// The table lives in one ram of TABLE_SIZE 8-bit entries (N = TABLE_SIZE below)
// and a single sequencer works one request at a time through its one read port,
// whose reads are registered. After reset a clearing pass over all N entries
// writes the reset table, during which no request is accepted (configuration
// writes are). Work per request: set writes its entry while idle, clear rewrites
// all N entries, allocate reads entries from address 2 up until it finds a free
// one, delete subtree checks entries 2..N-1 in turn and follows each one's parent
// chain (at most 255 steps per entry) before a final write of the target. The
// result then goes to the output register once the previous result has been
// taken; a new request is taken while a result is still waiting.
module tree_address_table_top #(
	parameter int TABLE_SIZE = 256
) (
	input logic     clk,
	input logic     arst_n,
	tat_req_if.sink   req,
	tat_rsp_if.source rsp,
	tat_cfg_if.sink   cfg
);
	import tat_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_SIZE - 1);
	localparam logic [AW-1:0] FIRST_IDX = AW'(FIRST_ALLOC);
	localparam logic [ADDR_W:0] SIZE_EXT = (ADDR_W + 1)'(TABLE_SIZE);
	localparam int CNT_W = $clog2(WALK_LIMIT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WALK_LIMIT - 1);

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_AL_RD  = 3'd2;
	localparam logic [2:0] ST_AL_CK  = 3'd3;
	localparam logic [2:0] ST_DL_RD  = 3'd4;
	localparam logic [2:0] ST_DL_CK  = 3'd5;
	localparam logic [2:0] ST_DL_TGT = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	function automatic logic in_range(addr_t a);
		return {1'b0, a} < SIZE_EXT;
	endfunction

	logic [2:0]       state_q;
	logic [AW-1:0]    idx_q;
	logic [CNT_W-1:0] cnt_q;
	addr_t            root_q;
	addr_t            fill_root_q;
	logic             clr_req_q;
	addr_t            tgt_q;
	addr_t            par_q;
	addr_t            chain_q;
	logic             use_rd_q;
	addr_t            asg_q;
	logic             stat_q;
	logic             out_valid_q;
	addr_t            out_asg_q;
	logic             out_stat_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	addr_t         ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	addr_t         ram_rdata;
	addr_t         cur;
	logic          last_entry;

	tat_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.assigned_address = out_asg_q;
	assign rsp.status = out_stat_q;

	// chain value under test: fresh ram data, or zero for an address past the table
	assign cur = use_rd_q ? ram_rdata : chain_q;
	assign last_entry = (idx_q == LAST_IDX);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = (ADDR_W'(idx_q) == fill_root_q) ? fill_root_q : '0;
			end
			ST_IDLE: begin
				if (req.valid && req.kind == KIND_SET && in_range(req.address)) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(req.address);
					ram_wdata = req.parent;
				end
			end
			ST_AL_RD, ST_DL_RD: begin
				ram_re = 1'b1;
			end
			ST_AL_CK: begin
				if (ram_rdata == '0) begin
					ram_we    = 1'b1;
					ram_wdata = par_q;
				end
			end
			ST_DL_CK: begin
				if (cur == tgt_q || cur == '0) begin
					ram_we = 1'b1;
				end else if (cur != root_q && cnt_q != CNT_LAST && in_range(cur)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cur);
				end
			end
			ST_DL_TGT: begin
				if (tgt_q != root_q && in_range(tgt_q)) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(tgt_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			cnt_q       <= '0;
			root_q      <= ADDR_W'(1);
			fill_root_q <= ADDR_W'(1);
			clr_req_q   <= 1'b0;
			tgt_q       <= '0;
			par_q       <= '0;
			chain_q     <= '0;
			use_rd_q    <= 1'b0;
			asg_q       <= '0;
			stat_q      <= STATUS_DONE;
			out_valid_q <= 1'b0;
			out_asg_q   <= '0;
			out_stat_q  <= STATUS_DONE;
		end else begin
			if (cfg.valid) begin
				root_q <= cfg.data;
			end
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (last_entry) begin
						idx_q   <= '0;
						state_q <= clr_req_q ? ST_DONE : ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						asg_q  <= '0;
						stat_q <= STATUS_DONE;
						tgt_q  <= req.address;
						par_q  <= (req.parent == '0) ? root_q : req.parent;
						case (req.kind)
							KIND_ALLOC: begin
								idx_q   <= FIRST_IDX;
								state_q <= ST_AL_RD;
							end
							KIND_SET: begin
								state_q <= ST_DONE;
							end
							KIND_DELETE: begin
								idx_q   <= FIRST_IDX;
								state_q <= ST_DL_RD;
							end
							default: begin
								idx_q       <= '0;
								fill_root_q <= root_q;
								clr_req_q   <= 1'b1;
								state_q     <= ST_CLR;
							end
						endcase
					end
				end
				ST_AL_RD: begin
					state_q <= ST_AL_CK;
				end
				ST_AL_CK: begin
					if (ram_rdata == '0) begin
						asg_q   <= ADDR_W'(idx_q);
						state_q <= ST_DONE;
					end else if (last_entry) begin
						stat_q  <= STATUS_FULL;
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_AL_RD;
					end
				end
				ST_DL_RD: begin
					use_rd_q <= 1'b1;
					cnt_q    <= '0;
					state_q  <= ST_DL_CK;
				end
				ST_DL_CK: begin
					if (cur == tgt_q || cur == '0 || cur == root_q || cnt_q == CNT_LAST) begin
						// this entry is settled, move to the next one
						if (last_entry) begin
							state_q <= ST_DL_TGT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DL_RD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (in_range(cur)) begin
							use_rd_q <= 1'b1;
						end else begin
							chain_q  <= '0;
							use_rd_q <= 1'b0;
						end
					end
				end
				ST_DL_TGT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_asg_q   <= asg_q;
						out_stat_q  <= stat_q;
						clr_req_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
